@@ src/iee_pkg.sv @@
// Shared types and constants for the infix expression evaluator.
package iee_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int VALUE_WIDTH_DEF = 48;

    localparam int CHAR_W   = 8;
    localparam int STATUS_W = 3;
    localparam int OP_W     = 3;

    // Operator codes held on the operator stack
    localparam logic [OP_W-1:0] OP_PAREN = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD   = 3'd1;
    localparam logic [OP_W-1:0] OP_SUB   = 3'd2;
    localparam logic [OP_W-1:0] OP_MUL   = 3'd3;
    localparam logic [OP_W-1:0] OP_DIV   = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DIV0 = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OVF  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SAT  = 3'd4;

    // Characters
    localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2a;
    localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2b;
    localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2d;
    localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2f;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last;
    } in_item_t;

    typedef struct packed {
        logic signed [VALUE_WIDTH_DEF-1:0] value;
        logic [STATUS_W-1:0]               status;
    } out_item_t;

    // Operation codes for the shared arithmetic unit
    typedef enum logic [2:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV,
        ALU_DIGIT
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_ctrl_t;

    typedef struct packed {
        logic done;
        logic sat;
    } alu_stat_t;

endpackage

@@ src/iee_alu.sv @@
// Shared multi-cycle arithmetic unit: saturating add, sub, digit step, multiply, divide.
module iee_alu #(
    parameter int FRAC_BITS   = iee_pkg::FRAC_BITS_DEF,
    parameter int VALUE_WIDTH = iee_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  iee_pkg::alu_ctrl_t            ctrl,
    input  logic signed [VALUE_WIDTH-1:0] opa,
    input  logic signed [VALUE_WIDTH-1:0] opb,
    output logic signed [VALUE_WIDTH-1:0] result,
    output iee_pkg::alu_stat_t            stat
);
    import iee_pkg::*;

    localparam int VW  = VALUE_WIDTH;
    localparam int MW  = VW;
    localparam int DW  = VW + FRAC_BITS;
    localparam int CW  = $clog2(DW + 1);
    localparam int PW  = 2 * MW;

    localparam logic [MW-1:0] VMAXM = {1'b0, {(MW-1){1'b1}}};
    localparam logic [MW-1:0] CAPM  = {1'b1, {(MW-1){1'b0}}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_FIN
    } alu_state_t;

    alu_state_t        state_reg, state_next;
    logic [MW-1:0]     ma_reg, ma_next;
    logic [MW-1:0]     mb_reg, mb_next;
    logic              neg_reg, neg_next;
    logic [PW-1:0]     acc_reg, acc_next;
    logic [DW-1:0]     dvd_reg, dvd_next;
    logic [MW:0]       rem_reg, rem_next;
    logic [DW-1:0]     quo_reg, quo_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [VW-1:0]     res_reg, res_next;
    logic              sat_reg, sat_next;
    logic              done_reg, done_next;

    logic [MW-1:0] mag_a, mag_b;
    logic [VW:0]   sum_x;
    logic [MW:0]   rem_sh;
    logic [MW:0]   rem_sub;
    logic [PW-1:0] prod_q;
    logic [MW-1:0] mag_f;
    logic          over_f;
    logic [MW+4:0] dig_x;

    assign mag_a = opa[VW-1] ? (~opa + 1'b1) : opa;
    assign mag_b = opb[VW-1] ? (~opb + 1'b1) : opb;
    assign rem_sh  = {rem_reg[MW-1:0], dvd_reg[DW-1]};
    assign rem_sub = rem_sh - {1'b0, mb_reg};
    assign prod_q  = acc_reg >> FRAC_BITS;
    assign dig_x   = ({5'd0, opa} << 3) + ({5'd0, opa} << 1) + {5'd0, opb};

    // Final magnitude and its overflow flag
    always_comb
    begin
        if (state_reg == S_DIV || quo_reg != '0 && acc_reg == '0)
        begin
            mag_f  = quo_reg[MW-1:0];
            over_f = (quo_reg >> MW) != '0;
        end
        else
        begin
            mag_f  = prod_q[MW-1:0];
            over_f = (prod_q >> MW) != '0;
        end
    end

    always_comb
    begin
        logic [MW-1:0] lim;
        logic [MW-1:0] m;
        logic          s;
        state_next = state_reg;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        res_next   = res_reg;
        sat_next   = 1'b0;
        done_next  = 1'b0;
        sum_x      = '0;
        lim        = '0;
        m          = '0;
        s          = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (ctrl.start)
                begin
                    unique case (ctrl.op)
                        ALU_ADD, ALU_SUB:
                        begin
                            if (ctrl.op == ALU_ADD)
                                sum_x = {opa[VW-1], opa} + {opb[VW-1], opb};
                            else
                                sum_x = {opa[VW-1], opa} - {opb[VW-1], opb};
                            if (sum_x[VW] != sum_x[VW-1])
                            begin
                                res_next = sum_x[VW] ? CAPM : VMAXM;
                                sat_next = 1'b1;
                            end
                            else
                                res_next = sum_x[VW-1:0];
                            done_next = 1'b1;
                        end
                        ALU_DIGIT:
                        begin
                            // opa is accumulator magnitude, opb is unit
                            if (dig_x > {5'd0, CAPM})
                            begin
                                res_next = CAPM;
                                sat_next = 1'b1;
                            end
                            else
                                res_next = dig_x[MW-1:0];
                            done_next = 1'b1;
                        end
                        ALU_MUL:
                        begin
                            ma_next   = mag_a;
                            mb_next   = mag_b;
                            neg_next  = opa[VW-1] ^ opb[VW-1];
                            acc_next  = '0;
                            quo_next  = '0;
                            cnt_next  = CW'(MW);
                            state_next = S_MUL;
                        end
                        ALU_DIV:
                        begin
                            mb_next   = mag_b;
                            neg_next  = opa[VW-1] ^ opb[VW-1];
                            dvd_next  = {mag_a, {FRAC_BITS{1'b0}}};
                            rem_next  = '0;
                            quo_next  = '0;
                            acc_next  = '0;
                            cnt_next  = CW'(DW);
                            state_next = S_DIV;
                        end
                        default: ;
                    endcase
                end
            end
            S_MUL:
            begin
                // Shift-add one multiplier bit per cycle
                acc_next = (acc_reg << 1) + (ma_reg[MW-1] ? {{MW{1'b0}}, mb_reg} : '0);
                ma_next  = ma_reg << 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                    state_next = S_FIN;
            end
            S_DIV:
            begin
                // Restoring division, one quotient bit per cycle
                dvd_next = dvd_reg << 1;
                quo_next = quo_reg << 1;
                if (rem_sh >= {1'b0, mb_reg})
                begin
                    rem_next    = rem_sub;
                    quo_next[0] = 1'b1;
                end
                else
                    rem_next = rem_sh;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    acc_next   = '0;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                m = over_f ? {MW{1'b1}} : mag_f;
                lim = VMAXM + {{(MW-1){1'b0}}, neg_reg};
                if (m > lim)
                begin
                    m = lim;
                    s = 1'b1;
                end
                res_next   = neg_reg ? (~m + 1'b1) : m;
                sat_next   = s;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sat_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sat_reg   <= sat_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ma_reg  <= ma_next;
        mb_reg  <= mb_next;
        neg_reg <= neg_next;
        acc_reg <= acc_next;
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
        res_reg <= res_next;
    end

    assign result    = res_reg;
    assign stat.done = done_reg;
    assign stat.sat  = sat_reg;

endmodule

@@ src/iee_ctrl.sv @@
// Parser and stack sequencer that drives the shared arithmetic unit.
module iee_ctrl #(
    parameter int STACK_DEPTH = iee_pkg::STACK_DEPTH_DEF,
    parameter int FRAC_BITS   = iee_pkg::FRAC_BITS_DEF,
    parameter int VALUE_WIDTH = iee_pkg::VALUE_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic [iee_pkg::CHAR_W-1:0]         in_char,
    input  logic                               in_last,
    output logic                               in_stall,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [VALUE_WIDTH-1:0]      out_value,
    output logic [iee_pkg::STATUS_W-1:0]       out_status,
    output iee_pkg::alu_ctrl_t                 alu_ctrl,
    output logic signed [VALUE_WIDTH-1:0]      alu_a,
    output logic signed [VALUE_WIDTH-1:0]      alu_b,
    input  logic signed [VALUE_WIDTH-1:0]      alu_res,
    input  iee_pkg::alu_stat_t                 alu_stat
);
    import iee_pkg::*;

    localparam int VW = VALUE_WIDTH;
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int NW = $clog2(STACK_DEPTH + 1);
    localparam logic [VW-1:0] VMAXV = {1'b0, {(VW-1){1'b1}}};
    localparam logic [VW-1:0] CAPV  = {1'b1, {(VW-1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIGIT,
        S_DIGW,
        S_TOKEN,
        S_CLOSE,
        S_APPLY,
        S_RED,
        S_REDW,
        S_END,
        S_OUT
    } ctrl_state_t;

    typedef enum logic [1:0] {
        RET_CLOSE,
        RET_APPLY
    } ret_t;

    ctrl_state_t         state_reg, state_next;
    ret_t                ret_reg, ret_next;
    logic signed [VW-1:0] vstack [STACK_DEPTH];
    logic [OP_W-1:0]     ostack [STACK_DEPTH];
    logic [NW-1:0]       vcnt_reg, vcnt_next;
    logic [NW-1:0]       ocnt_reg, ocnt_next;
    logic [VW-1:0]       nacc_reg, nacc_next;
    logic                innum_reg, innum_next;
    logic                nneg_reg, nneg_next;
    logic                oprdy_reg, oprdy_next;
    logic                pdig_reg, pdig_next;
    logic [STATUS_W-1:0] err_reg, err_next;
    logic [CHAR_W-1:0]   ch_reg, ch_next;
    logic                last_reg, last_next;
    logic                tail_reg, tail_next;
    logic [OP_W-1:0]     code_reg, code_next;
    logic signed [VW-1:0] opa_reg, opa_next;
    logic signed [VW-1:0] opb_reg, opb_next;
    alu_ctrl_t           actl_reg, actl_next;
    logic signed [VW-1:0] oval_reg, oval_next;
    logic [STATUS_W-1:0] ostat_reg, ostat_next;

    logic                vwe;
    logic [AW-1:0]       vwa;
    logic signed [VW-1:0] vwd;
    logic                owe;
    logic [AW-1:0]       owa;
    logic [OP_W-1:0]     owd;

    logic signed [VW-1:0] vtop1, vtop2;
    logic [OP_W-1:0]     otop;
    logic                hard;

    assign vtop1 = vstack[AW'(vcnt_reg - 1'b1)];
    assign vtop2 = vstack[AW'(vcnt_reg - 2'd2)];
    // The bottom slot is always read as the outer open parenthesis
    assign otop  = (ocnt_reg == NW'(1)) ? OP_PAREN : ostack[AW'(ocnt_reg - 1'b1)];
    assign hard  = (err_reg != ST_OK) && (err_reg != ST_SAT);

    // Write the stacks
    always_ff @(posedge clk)
    begin
        if (vwe)
            vstack[vwa] <= vwd;
        if (owe)
            ostack[owa] <= owd;
    end

    always_comb
    begin
        logic [STATUS_W-1:0] e;
        logic                dig;
        logic [OP_W-1:0]     cd;
        logic [VW-1:0]       mag;
        logic signed [VW-1:0] sv;
        logic                sat1;
        state_next = state_reg;
        ret_next   = ret_reg;
        vcnt_next  = vcnt_reg;
        ocnt_next  = ocnt_reg;
        nacc_next  = nacc_reg;
        innum_next = innum_reg;
        nneg_next  = nneg_reg;
        oprdy_next = oprdy_reg;
        pdig_next  = pdig_reg;
        e          = err_reg;
        ch_next    = ch_reg;
        last_next  = last_reg;
        tail_next  = tail_reg;
        code_next  = code_reg;
        opa_next   = opa_reg;
        opb_next   = opb_reg;
        actl_next  = '{start: 1'b0, op: ALU_ADD};
        oval_next  = oval_reg;
        ostat_next = ostat_reg;
        vwe = 1'b0; vwa = '0; vwd = '0;
        owe = 1'b0; owa = '0; owd = '0;
        dig  = (ch_reg >= CH_ZERO) && (ch_reg <= CH_NINE);
        cd   = (ch_reg == CH_PLUS)  ? OP_ADD :
               (ch_reg == CH_MINUS) ? OP_SUB :
               (ch_reg == CH_STAR)  ? OP_MUL :
               (ch_reg == CH_SLASH) ? OP_DIV : OP_PAREN;
        mag  = '0;
        sv   = '0;
        sat1 = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ch_next   = in_char;
                    last_next = in_last;
                    state_next = hard ? S_END : S_TOKEN;
                end
            end
            S_TOKEN:
            begin
                state_next = S_END;
                if (innum_reg && dig)
                    state_next = S_DIGIT;
                else if (innum_reg && ch_reg == CH_MINUS && !pdig_reg)
                    e = ST_BAD;
                else
                begin
                    // Finish a pending number first
                    if (innum_reg)
                    begin
                        innum_next = 1'b0;
                        pdig_next  = 1'b0;
                        if (!pdig_reg)
                            e = ST_BAD;
                        else
                        begin
                            mag = nacc_reg;
                            if (!nneg_reg && mag > VMAXV)
                            begin
                                mag  = VMAXV;
                                sat1 = 1'b1;
                            end
                            sv = nneg_reg ? VW'(~mag + 1'b1) : mag;
                            if (sat1 && e == ST_OK)
                                e = ST_SAT;
                            if (vcnt_reg >= NW'(STACK_DEPTH))
                                e = ST_OVF;
                            else
                            begin
                                vwe = 1'b1; vwa = AW'(vcnt_reg); vwd = sv;
                                vcnt_next = vcnt_reg + 1'b1;
                            end
                            nacc_next  = '0;
                            nneg_next  = 1'b0;
                            oprdy_next = 1'b1;
                        end
                    end
                    if (!((e != ST_OK) && (e != ST_SAT)))
                    begin
                        if (ch_reg == CH_LPAREN)
                        begin
                            if (oprdy_next)
                                e = ST_BAD;
                            else if (ocnt_reg >= NW'(STACK_DEPTH))
                                e = ST_OVF;
                            else
                            begin
                                owe = 1'b1; owa = AW'(ocnt_reg); owd = OP_PAREN;
                                ocnt_next = ocnt_reg + 1'b1;
                            end
                        end
                        else if (ch_reg == CH_RPAREN)
                        begin
                            if (!oprdy_next)
                                e = ST_BAD;
                            else
                                state_next = S_CLOSE;
                        end
                        else if (cd != OP_PAREN && oprdy_next)
                        begin
                            code_next = cd;
                            if (ocnt_reg == '0)
                                e = ST_BAD;
                            else
                                state_next = S_APPLY;
                        end
                        else if (ch_reg == CH_MINUS)
                        begin
                            innum_next = 1'b1;
                            nneg_next  = 1'b1;
                            nacc_next  = '0;
                            pdig_next  = 1'b0;
                        end
                        else if (dig)
                        begin
                            innum_next = 1'b1;
                            nneg_next  = 1'b0;
                            nacc_next  = '0;
                            state_next = S_DIGIT;
                        end
                        else
                            e = ST_BAD;
                    end
                end
            end
            S_DIGIT:
            begin
                // One decimal step on the shared unit
                opa_next  = (innum_reg && state_reg == S_DIGIT && nacc_reg != '0)
                            ? nacc_reg : '0;
                opb_next  = VW'({4'd0, ch_reg[3:0]}) << FRAC_BITS;
                if (FRAC_BITS + 4 > VW - 1 &&
                    (VW'({4'd0, ch_reg[3:0]}) << FRAC_BITS) >> FRAC_BITS
                    != VW'({4'd0, ch_reg[3:0]}))
                    opb_next = CAPV;
                actl_next = '{start: 1'b1, op: ALU_DIGIT};
                state_next = S_DIGW;
            end
            S_DIGW:
            begin
                if (alu_stat.done)
                begin
                    nacc_next = alu_res;
                    pdig_next = 1'b1;
                    if (alu_stat.sat && e == ST_OK)
                        e = ST_SAT;
                    state_next = S_END;
                end
            end
            S_CLOSE:
            begin
                if (ocnt_reg == '0)
                begin
                    e = ST_BAD;
                    state_next = S_END;
                end
                else if (otop == OP_PAREN)
                begin
                    ocnt_next  = ocnt_reg - 1'b1;
                    state_next = S_END;
                end
                else
                begin
                    ret_next   = RET_CLOSE;
                    state_next = S_RED;
                end
            end
            S_APPLY:
            begin
                if (ocnt_reg == '0 || otop == OP_PAREN ||
                    ((otop == OP_ADD || otop == OP_SUB) &&
                     (code_reg == OP_MUL || code_reg == OP_DIV)))
                begin
                    if (ocnt_reg >= NW'(STACK_DEPTH))
                        e = ST_OVF;
                    else
                    begin
                        owe = 1'b1; owa = AW'(ocnt_reg); owd = code_reg;
                        ocnt_next  = ocnt_reg + 1'b1;
                        oprdy_next = 1'b0;
                    end
                    state_next = S_END;
                end
                else
                begin
                    ret_next   = RET_APPLY;
                    state_next = S_RED;
                end
            end
            S_RED:
            begin
                // Pop one operator and two values, start the unit
                if (vcnt_reg < NW'(2))
                begin
                    e = ST_BAD;
                    state_next = S_END;
                end
                else
                begin
                    ocnt_next = ocnt_reg - 1'b1;
                    vcnt_next = vcnt_reg - NW'(2);
                    opa_next  = vtop2;
                    opb_next  = vtop1;
                    state_next = S_REDW;
                    unique case (otop)
                        OP_ADD: actl_next = '{start: 1'b1, op: ALU_ADD};
                        OP_SUB: actl_next = '{start: 1'b1, op: ALU_SUB};
                        OP_MUL: actl_next = '{start: 1'b1, op: ALU_MUL};
                        OP_DIV:
                        begin
                            if (vtop1 == '0)
                            begin
                                e = ST_DIV0;
                                state_next = S_END;
                            end
                            else
                                actl_next = '{start: 1'b1, op: ALU_DIV};
                        end
                        default:
                        begin
                            e = ST_BAD;
                            state_next = S_END;
                        end
                    endcase
                end
            end
            S_REDW:
            begin
                if (alu_stat.done)
                begin
                    if (alu_stat.sat && e == ST_OK)
                        e = ST_SAT;
                    vwe = 1'b1; vwa = AW'(vcnt_reg); vwd = alu_res;
                    vcnt_next  = vcnt_reg + 1'b1;
                    state_next = (ret_reg == RET_CLOSE) ? S_CLOSE : S_APPLY;
                end
            end
            S_END:
            begin
                // Closing work for the final character
                if (!last_reg)
                    state_next = S_IDLE;
                else if ((e != ST_OK) && (e != ST_SAT))
                begin
                    oval_next  = '0;
                    ostat_next = e;
                    state_next = S_OUT;
                end
                else if (!tail_reg)
                begin
                    // Apply the closing parenthesis implied at the end
                    tail_next  = 1'b1;
                    ch_next    = CH_RPAREN;
                    state_next = S_TOKEN;
                end
                else if (ocnt_reg != '0 || vcnt_reg != NW'(1))
                begin
                    oval_next  = '0;
                    ostat_next = ST_BAD;
                    state_next = S_OUT;
                end
                else
                begin
                    oval_next  = vstack[0];
                    ostat_next = e;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    vcnt_next  = '0;
                    ocnt_next  = NW'(1);
                    owe = 1'b1; owa = '0; owd = OP_PAREN;
                    nacc_next  = '0;
                    innum_next = 1'b0;
                    nneg_next  = 1'b0;
                    oprdy_next = 1'b0;
                    pdig_next  = 1'b0;
                    tail_next  = 1'b0;
                    e          = ST_OK;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        err_next = e;
    end

    // Hold control state; clear on reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= RET_CLOSE;
            vcnt_reg  <= '0;
            ocnt_reg  <= NW'(1);
            nacc_reg  <= '0;
            innum_reg <= 1'b0;
            nneg_reg  <= 1'b0;
            oprdy_reg <= 1'b0;
            pdig_reg  <= 1'b0;
            tail_reg  <= 1'b0;
            err_reg   <= ST_OK;
            code_reg  <= OP_PAREN;
            actl_reg  <= '{start: 1'b0, op: ALU_ADD};
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            vcnt_reg  <= vcnt_next;
            ocnt_reg  <= ocnt_next;
            nacc_reg  <= nacc_next;
            innum_reg <= innum_next;
            nneg_reg  <= nneg_next;
            oprdy_reg <= oprdy_next;
            pdig_reg  <= pdig_next;
            tail_reg  <= tail_next;
            err_reg   <= err_next;
            code_reg  <= (state_next == S_IDLE) ? OP_PAREN : code_next;
            actl_reg  <= actl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg    <= ch_next;
        last_reg  <= last_next;
        opa_reg   <= opa_next;
        opb_reg   <= opb_next;
        oval_reg  <= oval_next;
        ostat_reg <= ostat_next;
    end

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = (state_reg == S_OUT);
    assign out_value  = oval_reg;
    assign out_status = ostat_reg;
    assign alu_ctrl   = actl_reg;
    assign alu_a      = opa_reg;
    assign alu_b      = opb_reg;

endmodule

@@ src/infix_expression_evaluator.sv @@
// Top level of the infix expression evaluator.
// Usage:
//   Characters enter on the in channel (in_valid, in_stall, in_item with
//   char_code and last). An item is taken when in_valid is high and
//   in_stall low. in_stall stays high while a character is worked on.
//   A digit is one decimal step on the shared arithmetic unit; an operator
//   or parenthesis may first pop operators, each popped operator being one
//   reduction (add, subtract, multiply or divide), all on the one shared
//   arithmetic unit. On the character marked last the implicit closing
//   parenthesis is applied, with its reductions, and one result item
//   (value, status) is shown on out_valid.
//   It holds while out_stall is high; no new character is taken until it
//   leaves. Reset empties both stacks, leaves one open parenthesis on the
//   operator stack and clears the error status. No clearing pass is run.
module infix_expression_evaluator #(
    parameter int STACK_DEPTH = iee_pkg::STACK_DEPTH_DEF,
    parameter int FRAC_BITS   = iee_pkg::FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  iee_pkg::in_item_t   in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output iee_pkg::out_item_t  out_item
);
    import iee_pkg::*;

    localparam int VALUE_WIDTH = VALUE_WIDTH_DEF;

    alu_ctrl_t                     alu_ctrl;
    alu_stat_t                     alu_stat;
    logic signed [VALUE_WIDTH-1:0] alu_a, alu_b, alu_res, res_value;
    logic [STATUS_W-1:0]           res_status;

    iee_ctrl #(
        .STACK_DEPTH (STACK_DEPTH),
        .FRAC_BITS   (FRAC_BITS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_char    (in_item.char_code),
        .in_last    (in_item.last),
        .in_stall   (in_stall),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_value  (res_value),
        .out_status (res_status),
        .alu_ctrl   (alu_ctrl),
        .alu_a      (alu_a),
        .alu_b      (alu_b),
        .alu_res    (alu_res),
        .alu_stat   (alu_stat)
    );

    iee_alu #(
        .FRAC_BITS   (FRAC_BITS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (alu_ctrl),
        .opa    (alu_a),
        .opb    (alu_b),
        .result (alu_res),
        .stat   (alu_stat)
    );

    assign out_item.value  = res_value;
    assign out_item.status = res_status;

    // Never take a character while a result is on offer
    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> in_stall)
        else $error("character taken while result pending");

    // Status stays within defined codes
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.status <= ST_SAT))
        else $error("undefined status code");

    // An error status carries a zero value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.status == ST_DIV0 || out_item.status == ST_OVF ||
                      out_item.status == ST_BAD) |-> (out_item.value == '0))
        else $error("non-zero value with error status");

endmodule

@@ tb/tb_infix_expression_evaluator.sv @@
// Self-checking testbench for the infix expression evaluator: characters in, results predicted and checked.
module tb_infix_expression_evaluator;
    import iee_pkg::*;

    localparam int DEPTH = STACK_DEPTH_DEF;
    localparam int FRAC  = FRAC_BITS_DEF;
    localparam int VW    = VALUE_WIDTH_DEF;
    localparam longint unsigned CYCLE_LIMIT = 64'd3_000_000;

    localparam logic signed [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    in_item_t in_item;
    logic out_valid;
    logic out_stall;
    out_item_t out_item;

    infix_expression_evaluator dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Evaluator state mirrored by the predictor
    logic signed [VW-1:0] operands [DEPTH];
    logic [OP_W-1:0]      operators [DEPTH];
    int                   operand_cnt;
    int                   operator_cnt;
    logic [63:0]          num_mag;
    bit                   num_open;
    bit                   num_neg;
    bit                   have_operand;
    bit                   saw_digit;
    logic [STATUS_W-1:0]  err;

    in_item_t  pending_chars [$];
    out_item_t expected_results [$];
    int        fail_count;
    int        result_count;
    int        expr_count;
    bit        stim_done;
    bit        hold_off;
    longint unsigned cycles;

    function automatic bit is_hard();
        return err != ST_OK && err != ST_SAT;
    endfunction

    function automatic void raise(logic [STATUS_W-1:0] e);
        if (!is_hard())
            err = e;
    endfunction

    function automatic void note_clamp();
        if (err == ST_OK)
            err = ST_SAT;
    endfunction

    function automatic void clear_state();
        operand_cnt  = 0;
        operators[0] = OP_PAREN;
        operator_cnt = 1;
        num_mag      = 0;
        num_open     = 0;
        num_neg      = 0;
        have_operand = 0;
        saw_digit    = 0;
        err          = ST_OK;
    endfunction

    function automatic logic [63:0] mag_of(logic signed [VW-1:0] v);
        logic signed [63:0] w;
        w = v;
        return w < 0 ? -w : w;
    endfunction

    // Clamp a magnitude with sign into the value range
    function automatic logic signed [VW-1:0] signed_from(logic [63:0] m, bit neg);
        logic [63:0] lim;
        logic signed [63:0] r;
        lim = 64'(VAL_MAX) + (neg ? 64'd1 : 64'd0);
        if (m > lim)
        begin
            m = lim;
            note_clamp();
        end
        r = neg ? -$signed(m) : $signed(m);
        return r[VW-1:0];
    endfunction

    function automatic logic signed [VW-1:0] add_sat(logic signed [VW-1:0] a,
                                                     logic signed [VW-1:0] b);
        logic signed [VW+1:0] s;
        s = a + b;
        if (s > VAL_MAX)
        begin
            note_clamp();
            return VAL_MAX;
        end
        if (s < VAL_MIN)
        begin
            note_clamp();
            return VAL_MIN;
        end
        return s[VW-1:0];
    endfunction

    function automatic logic signed [VW-1:0] sub_sat(logic signed [VW-1:0] a,
                                                     logic signed [VW-1:0] b);
        logic signed [VW+1:0] s;
        s = a - b;
        if (s > VAL_MAX)
        begin
            note_clamp();
            return VAL_MAX;
        end
        if (s < VAL_MIN)
        begin
            note_clamp();
            return VAL_MIN;
        end
        return s[VW-1:0];
    endfunction

    function automatic logic signed [VW-1:0] mul_fixed(logic signed [VW-1:0] a,
                                                       logic signed [VW-1:0] b);
        logic [127:0] p;
        p = {64'd0, mag_of(a)} * {64'd0, mag_of(b)};
        p = p >> FRAC;
        return signed_from(p[127:64] != 0 ? {64{1'b1}} : p[63:0], (a < 0) != (b < 0));
    endfunction

    function automatic logic signed [VW-1:0] div_fixed(logic signed [VW-1:0] n,
                                                       logic signed [VW-1:0] d);
        logic [127:0] q;
        q = ({64'd0, mag_of(n)} << FRAC) / {64'd0, mag_of(d)};
        return signed_from(q[127:64] != 0 ? {64{1'b1}} : q[63:0], (n < 0) != (d < 0));
    endfunction

    function automatic void push_operand(logic signed [VW-1:0] v);
        if (operand_cnt >= DEPTH)
        begin
            raise(ST_OVF);
            return;
        end
        operands[operand_cnt] = v;
        operand_cnt++;
    endfunction

    function automatic void push_operator(logic [OP_W-1:0] op);
        if (operator_cnt >= DEPTH)
        begin
            raise(ST_OVF);
            return;
        end
        operators[operator_cnt] = op;
        operator_cnt++;
    endfunction

    // Pop one operator and its two operands, push the outcome
    function automatic void reduce_top();
        logic signed [VW-1:0] rhs, lhs, res;
        logic [OP_W-1:0] op;
        if (operator_cnt == 0 || operand_cnt < 2)
        begin
            raise(ST_BAD);
            return;
        end
        operator_cnt--;
        op  = operators[operator_cnt];
        rhs = operands[operand_cnt-1];
        lhs = operands[operand_cnt-2];
        operand_cnt -= 2;
        res = 0;
        case (op)
            OP_ADD: res = add_sat(lhs, rhs);
            OP_SUB: res = sub_sat(lhs, rhs);
            OP_MUL: res = mul_fixed(lhs, rhs);
            OP_DIV:
            begin
                if (rhs == 0)
                begin
                    raise(ST_DIV0);
                    return;
                end
                res = div_fixed(lhs, rhs);
            end
            default:
            begin
                raise(ST_BAD);
                return;
            end
        endcase
        push_operand(res);
    endfunction

    function automatic void append_digit(int d);
        logic [63:0] cap, unit;
        cap  = 64'(VAL_MAX) + 64'd1;
        unit = 64'(d) << FRAC;
        if (unit > cap || num_mag > (cap - unit) / 10)
        begin
            num_mag = cap;
            note_clamp();
        end
        else
            num_mag = num_mag * 10 + unit;
        saw_digit = 1;
    endfunction

    function automatic void close_number();
        bit had;
        had       = saw_digit;
        num_open  = 0;
        saw_digit = 0;
        if (!had)
        begin
            raise(ST_BAD);
            return;
        end
        push_operand(signed_from(num_mag, num_neg));
        num_mag      = 0;
        num_neg      = 0;
        have_operand = 1;
    endfunction

    function automatic void close_group();
        if (!have_operand)
        begin
            raise(ST_BAD);
            return;
        end
        while (!is_hard())
        begin
            if (operator_cnt == 0)
            begin
                raise(ST_BAD);
                return;
            end
            if (operators[operator_cnt-1] == OP_PAREN)
            begin
                operator_cnt--;
                return;
            end
            reduce_top();
        end
    endfunction

    function automatic void take_operator(logic [OP_W-1:0] op);
        logic [OP_W-1:0] top;
        if (operator_cnt == 0)
        begin
            raise(ST_BAD);
            return;
        end
        while (!is_hard() && operator_cnt > 0)
        begin
            top = operators[operator_cnt-1];
            if (top == OP_PAREN)
                break;
            if ((top == OP_ADD || top == OP_SUB) && (op == OP_MUL || op == OP_DIV))
                break;
            reduce_top();
        end
        if (is_hard())
            return;
        push_operator(op);
        have_operand = 0;
    endfunction

    function automatic void take_char(logic [CHAR_W-1:0] c);
        bit digit;
        logic [OP_W-1:0] op;
        digit = c >= CH_ZERO && c <= CH_NINE;
        case (c)
            CH_PLUS:  op = OP_ADD;
            CH_MINUS: op = OP_SUB;
            CH_STAR:  op = OP_MUL;
            CH_SLASH: op = OP_DIV;
            default:  op = OP_PAREN;
        endcase
        if (num_open)
        begin
            if (digit)
            begin
                append_digit(int'(c - CH_ZERO));
                return;
            end
            if (c == CH_MINUS && !saw_digit)
            begin
                raise(ST_BAD);
                return;
            end
            close_number();
            if (is_hard())
                return;
        end
        if (c == CH_LPAREN)
        begin
            if (have_operand)
                raise(ST_BAD);
            else
                push_operator(OP_PAREN);
        end
        else if (c == CH_RPAREN)
            close_group();
        else if (op != OP_PAREN && have_operand)
            take_operator(op);
        else if (c == CH_MINUS)
        begin
            num_open  = 1;
            num_neg   = 1;
            num_mag   = 0;
            saw_digit = 0;
        end
        else if (digit)
        begin
            num_open = 1;
            num_neg  = 0;
            num_mag  = 0;
            append_digit(int'(c - CH_ZERO));
        end
        else
            raise(ST_BAD);
    endfunction

    // Advance the predictor by one accepted character
    function automatic void predict_char(in_item_t it);
        out_item_t r;
        if (!is_hard())
            take_char(it.char_code);
        if (!it.last)
            return;
        if (!is_hard() && num_open)
            close_number();
        if (!is_hard())
            close_group();
        if (!is_hard() && (operator_cnt != 0 || operand_cnt != 1))
            raise(ST_BAD);
        r.value  = is_hard() ? '0 : operands[0];
        r.status = err;
        expected_results = {expected_results, r};
        clear_state();
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch on result %0d: %s got %0d expected %0d",
                 result_count, what, got, want);
        fail_count++;
    endtask

    // Queue one expression as characters, last marked on the final one
    task automatic queue_text(string s);
        in_item_t it;
        for (int i = 0; i < s.len(); i++)
        begin
            it.char_code = s[i];
            it.last      = (i == s.len() - 1);
            pending_chars = {pending_chars, it};
        end
        expr_count++;
    endtask

    function automatic string rand_number();
        string s;
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 16) : $urandom_range(1, 3);
        s = "";
        for (int i = 0; i < n; i++)
            s = {s, string'(byte'(CH_ZERO + $urandom_range(0, 9)))};
        if ($urandom_range(0, 4) == 0)
            s = {"-", s};
        return s;
    endfunction

    function automatic string rand_expr(int lvl);
        string s, ops;
        int terms;
        ops = "+-*/";
        terms = $urandom_range(1, 4);
        s = "";
        for (int i = 0; i < terms; i++)
        begin
            if (i > 0)
                s = {s, string'(ops[$urandom_range(0, 3)])};
            if (lvl < 4 && $urandom_range(0, 3) == 0)
                s = {s, "(", rand_expr(lvl + 1), ")"};
            else
                s = {s, rand_number()};
        end
        return s;
    endfunction

    // Break a well-formed expression now and then, or send raw noise
    function automatic string mangle(string s);
        string noise;
        string marks;
        int k;
        marks = "()+-*/";
        case ($urandom_range(0, 3))
            0:
            begin
                k = $urandom_range(0, s.len() - 1);
                s[k] = byte'($urandom_range(0, 255));
            end
            1: s = {s, string'(marks[$urandom_range(0, 5)])};
            2: s = {"(", s};
            default:
            begin
                noise = "";
                k = $urandom_range(1, 6);
                for (int i = 0; i < k; i++)
                    noise = {noise, string'(byte'($urandom_range(0, 255)))};
                s = noise;
            end
        endcase
        return s;
    endfunction

    // Fill the queue: directed cases, then random expressions
    initial
    begin
        string s;
        fail_count = 0;
        result_count = 0;
        expr_count = 0;
        stim_done = 0;
        clear_state();
        queue_text("0");
        queue_text("1+2*3");
        queue_text("(1+2)*3");
        queue_text("8-3-2");
        queue_text("7/2");
        queue_text("-5*-3");
        queue_text("4/0");
        queue_text("--3");
        queue_text("3+)");
        queue_text("((2)");
        queue_text("2)");
        queue_text("99999999999*99999999");
        queue_text("9999999999999999");
        queue_text("-2147483648-1");
        queue_text("1+((((((((((((((((1))))))))))))))))");
        queue_text("1+2+3+4+5+6+7+8+9+1+2+3+4+5+6+7+8+9");
        queue_text("1*2+3*4-5/6+7*8");
        queue_text("x");
        queue_text("3(4)");
        queue_text("-");
        while (pending_chars.size() < 1950)
        begin
            s = rand_expr(0);
            if ($urandom_range(0, 5) == 0)
                s = mangle(s);
            queue_text(s);
        end
        stim_done = 1;
    end

    // Drive characters in bursts with random gaps
    int burst_left;
    int gap_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            in_item    <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            automatic bit taken = in_valid && !in_stall;
            automatic bit busy  = in_valid && !taken;
            if (taken)
                predict_char(in_item);
            if (!busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_chars.size() > 0)
                begin
                    in_item  <= pending_chars.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Stall the output on a pattern of its own, with one long hold-off
    int stall_phase;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall   <= 1'b0;
            stall_phase <= 0;
        end
        else
        begin
            stall_phase <= stall_phase + 1;
            if (hold_off)
                out_stall <= 1'b1;
            else if (stall_phase[9:8] == 2'd3)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(0, 3) == 0);
        end
    end

    initial
    begin
        hold_off = 0;
        wait (rst_n && expr_count > 40);
        repeat (3000) @(posedge clk);
        hold_off = 1;
        repeat (4000) @(posedge clk);
        hold_off = 0;
    end

    // Check every accepted result against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected value", out_item.value, 0);
            else
            begin
                automatic out_item_t want = expected_results.pop_front();
                if (out_item.status !== want.status)
                    report_mismatch("status", out_item.status, want.status);
                if (out_item.value !== want.value)
                    report_mismatch("value", out_item.value, want.value);
            end
            result_count++;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("infix_expression_evaluator regression: fail");
            $finish;
        end
    end

    initial
    begin
        cycles = 0;
        rst_n  = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        wait (stim_done && pending_chars.size() == 0);
        @(posedge clk);
        while (in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        $display("covered %0d expressions, %0d results checked, %0d failures",
                 expr_count, result_count, fail_count);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("infix_expression_evaluator regression: pass");
        else
            $display("infix_expression_evaluator regression: fail");
        $finish;
    end

endmodule
